FILE: rtl/rhbe_pkg.sv
// Package with the shared constants, state encoding and control structs of the rolling hash expander.
package rhbe_pkg;

    // Default number of digest words emitted per message.
    localparam int DIGEST_WORDS_DEF = 8;

    // Mixing constants of the digest stage.
    localparam logic [31:0] SEED_XOR  = 32'hA3C59AC3;
    localparam logic [31:0] MIX_MULT  = 32'h9E3779B9;
    localparam int          MIX_SHIFT = 16;

    // Width of the word index field on the result channel.
    localparam int BLOCK_NUMBER_W = 3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic absorb;    // take the byte of an accepted request
        logic finish;    // the byte closes the message: snapshot and clear
        logic seed;      // load the working word for the current index
        logic mix;       // multiply and fold the working word
        logic emit;      // final multiply into the output register
        logic step_idx;  // advance to the next digest word
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_word;  // current index is the final digest word
        logic out_free;   // output register can take a word this cycle
    } dp_sts_t;

endpackage

FILE: rtl/rhbe_datapath.sv
// Datapath of the rolling hash expander: accumulator, digest mixer and output register.
module rhbe_datapath #(
    parameter int DIGEST_WORDS = rhbe_pkg::DIGEST_WORDS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [7:0]                          s_data_byte,
    input  rhbe_pkg::dp_cmd_t                   cmd,
    output rhbe_pkg::dp_sts_t                   sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [31:0]                         m_block_value,
    output logic [rhbe_pkg::BLOCK_NUMBER_W-1:0] m_block_number,
    output logic                                m_last_block
);

    localparam int IDX_W = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;
    localparam int NUM_W = rhbe_pkg::BLOCK_NUMBER_W;

    logic [31:0]      acc_reg;
    logic [31:0]      acc_next;
    logic [31:0]      snap_reg;
    logic [31:0]      x_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      acc_upd;
    logic [31:0]      shifted;
    logic [31:0]      prod;
    logic [31:0]      folded;
    logic [IDX_W+NUM_W-1:0] idx_ext;
    logic             m_valid_reg;
    logic [31:0]      value_reg;
    logic [NUM_W-1:0] number_reg;
    logic             last_reg;

    // Accumulator times 31 plus the byte, as shift and subtract.
    assign acc_upd = {acc_reg[26:0], 5'b0} - acc_reg + {24'b0, s_data_byte};

    always_comb begin
        acc_next = acc_reg;
        if (cmd.absorb) begin
            acc_next = cmd.finish ? 32'b0 : acc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 32'b0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // Snapshot of the finished hash, held while the digest words are produced.
    always_ff @(posedge aclk) begin
        if (cmd.absorb && cmd.finish) begin
            snap_reg <= acc_upd;
        end
    end

    // Digest word index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.absorb && cmd.finish) begin
            idx_reg <= '0;
        end else if (cmd.step_idx) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Shared multiplier; one multiply per cycle on the working word, held while the output register is not free.
    assign shifted = 32'($signed(snap_reg) >>> idx_reg);
    assign prod    = 32'(x_reg * rhbe_pkg::MIX_MULT);
    assign folded  = prod ^ (prod >> rhbe_pkg::MIX_SHIFT);

    always_ff @(posedge aclk) begin
        if (cmd.seed) begin
            x_reg <= shifted ^ rhbe_pkg::SEED_XOR;
        end else if (cmd.mix) begin
            x_reg <= folded;
        end
    end

    // Output register; it is free when empty or when its word is being taken.
    assign idx_ext = {{NUM_W{1'b0}}, idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            value_reg  <= prod;
            number_reg <= idx_ext[NUM_W-1:0];
            last_reg   <= sts.last_word;
        end
    end

    assign sts.last_word = (idx_reg == IDX_W'(DIGEST_WORDS - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_block_value  = value_reg;
    assign m_block_number = number_reg;
    assign m_last_block   = last_reg;

endmodule

FILE: rtl/rhbe_ctrl.sv
// Controller state machine of the rolling hash expander.
module rhbe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_end_of_message,
    input  rhbe_pkg::dp_sts_t sts,
    output rhbe_pkg::dp_cmd_t cmd
);

    rhbe_pkg::state_t state_reg;
    rhbe_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rhbe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            rhbe_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.absorb = 1'b1;
                    cmd.finish = s_end_of_message;
                    if (s_end_of_message) begin
                        state_next = rhbe_pkg::ST_SEED;
                    end
                end
            end
            rhbe_pkg::ST_SEED: begin
                cmd.seed   = 1'b1;
                state_next = rhbe_pkg::ST_MIX1;
            end
            rhbe_pkg::ST_MIX1: begin
                cmd.mix    = 1'b1;
                state_next = rhbe_pkg::ST_MIX2;
            end
            rhbe_pkg::ST_MIX2: begin
                cmd.mix    = 1'b1;
                state_next = rhbe_pkg::ST_MIX3;
            end
            rhbe_pkg::ST_MIX3: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last_word) begin
                        state_next = rhbe_pkg::ST_IDLE;
                    end else begin
                        cmd.step_idx = 1'b1;
                        state_next   = rhbe_pkg::ST_SEED;
                    end
                end
            end
            default: begin
                state_next = rhbe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rolling_hash_block_expander.sv
// Top level of the rolling hash expander: controller, datapath and checks.
//
// Input channel (s_): one message byte per request, with s_end_of_message
// marking the final byte. Each byte is folded into a 32-bit accumulator as
// acc * 31 + byte. Bytes that do not end the message are taken back to back,
// so a message streams in at one byte per cycle.
// On the final byte the hash is captured and the accumulator cleared, and
// DIGEST_WORDS words leave on the result channel (m_), word 0 first, with
// m_block_number giving the index modulo 8 and m_last_block flagging the
// final word. Each word passes one shared 32x32 multiplier three times: the
// SEED state loads the working word, MIX1 and MIX2 multiply and fold it, and
// MIX3 makes the final multiply into the output register. The next message is
// taken as soon as the last word sits in the output register.
// If the receiver stalls, the finished word holds in the output register and
// the next word waits in the mixer until that register frees up.
// Reset (aresetn, synchronous, active low) clears the accumulator, drops
// m_valid and returns the controller to accepting bytes.
module rolling_hash_block_expander #(
    parameter int DIGEST_WORDS = rhbe_pkg::DIGEST_WORDS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_end_of_message,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [31:0]                         m_block_value,
    output logic [rhbe_pkg::BLOCK_NUMBER_W-1:0] m_block_number,
    output logic                                m_last_block
);

    localparam int NUM_W = rhbe_pkg::BLOCK_NUMBER_W;

    rhbe_pkg::dp_cmd_t cmd;
    rhbe_pkg::dp_sts_t sts;

    rhbe_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_end_of_message (s_end_of_message),
        .sts              (sts),
        .cmd              (cmd)
    );

    rhbe_datapath #(
        .DIGEST_WORDS (DIGEST_WORDS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_data_byte      (s_data_byte),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_block_value    (m_block_value),
        .m_block_number   (m_block_number),
        .m_last_block     (m_last_block)
    );

    // A final byte starts the digest, so no byte is taken in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_message |=> !s_ready)
        else $error("byte request accepted while a digest is being produced");

    // The word flagged last carries the final index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_block |->
            m_block_number == NUM_W'(DIGEST_WORDS - 1))
        else $error("last digest word carries the wrong index");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the rolling hash expander: byte stream in, digest words out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Digest shape and mixing constants; all but the index width are kept independent of the RTL.
    localparam int          NUM_WORDS   = 8;
    localparam logic [31:0] HASH_MULT   = 32'd31;
    localparam logic [31:0] SEED_MASK   = 32'hA3C59AC3;
    localparam logic [31:0] GOLDEN_MULT = 32'h9E3779B9;
    localparam int          FOLD_SHIFT  = 16;
    localparam int          NW          = rhbe_pkg::BLOCK_NUMBER_W;

    // Run length guards.
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 60;

    // One expected digest word.
    typedef struct {
        logic [31:0]   value;
        logic [NW-1:0] number;
        logic          last;
    } digest_word_t;

    logic          aclk;
    logic          aresetn          = 1'b0;
    logic          s_valid          = 1'b0;
    logic          s_ready;
    logic [7:0]    s_data_byte      = 8'h00;
    logic          s_end_of_message = 1'b0;
    logic          m_valid;
    logic          m_ready          = 1'b0;
    logic [31:0]   m_block_value;
    logic [NW-1:0] m_block_number;
    logic          m_last_block;

    // Predictor state and the words it still expects.
    logic [31:0]  hash_acc = 32'h0;
    digest_word_t digest_q[$];

    // Idling controls for the sender and the receiver.
    bit sender_idle   = 1'b0;
    bit receiver_idle = 1'b0;
    bit hold_request  = 1'b0;

    int errors        = 0;
    int bytes_sent    = 0;
    int messages_sent = 0;
    int words_checked = 0;
    int longest_msg   = 0;
    int cur_len       = 0;
    int cycle_count   = 0;

    rolling_hash_block_expander #(
        .DIGEST_WORDS(NUM_WORDS)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_block_value    (m_block_value),
        .m_block_number   (m_block_number),
        .m_last_block     (m_last_block)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Word idx of the digest: sign-extending shift, seed, then three multiplies with folds between.
    function automatic logic [31:0] mix_digest_word(input logic [31:0] acc, input int idx);
        logic [31:0] x;
        x = $signed(acc) >>> idx;
        x = x ^ SEED_MASK;
        x = x * GOLDEN_MULT;
        x = x ^ (x >> FOLD_SHIFT);
        x = x * GOLDEN_MULT;
        x = x ^ (x >> FOLD_SHIFT);
        x = x * GOLDEN_MULT;
        return x;
    endfunction

    // Fold an accepted byte into the hash; a closing byte queues the whole digest.
    function automatic void hash_byte(input logic [7:0] data, input logic eom);
        digest_word_t w;
        hash_acc = hash_acc * HASH_MULT + {24'h0, data};
        bytes_sent++;
        cur_len++;
        if (eom) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                w.value  = mix_digest_word(hash_acc, k);
                w.number = k[NW-1:0];
                w.last   = (k == NUM_WORDS - 1);
                digest_q.push_back(w);
            end
            hash_acc = 32'h0;
            messages_sent++;
            if (cur_len > longest_msg) begin
                longest_msg = cur_len;
            end
            cur_len = 0;
        end
    endfunction

    // Offer one byte request and wait for it to be taken.
    task automatic send_byte(input logic [7:0] data, input logic eom);
        int gap;
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= data;
        s_end_of_message <= eom;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hash_byte(data, eom);
    endtask

    // Send a whole message; only its final byte carries the end marker.
    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[i]) begin
            send_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
    endtask

    // A random message; most are short, a few are long enough to wrap the hash many times.
    task automatic send_random_message(output int len);
        logic [7:0] msg[$];
        int sel;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                msg.push_back(8'h00);
            end else if (sel == 1) begin
                msg.push_back(8'hFF);
            end else begin
                msg.push_back(8'($urandom()));
            end
        end
        send_message(msg);
    endtask

    // Single-byte messages at both ends of the byte range.
    task automatic test_single_byte();
        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'h80});
    endtask

    // Short multi-byte messages of two and three bytes, sent back to back.
    task automatic test_short_messages();
        send_message('{8'h01, 8'h7F});
        send_message('{8'h80, 8'h00, 8'h55});
    endtask

    // A run of 0xFF bytes pushes the hash through several wraps of 2^32.
    task automatic test_overflow();
        logic [7:0] msg[$];
        for (int i = 0; i < 9; i++) begin
            msg.push_back(8'hFF);
        end
        send_message(msg);
    endtask

    // Receiver holds off for a long stretch while requests keep coming, then the sender pauses.
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int m = 0; m < 3; m++) begin
            send_message('{8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom())});
        end
        wait_drained();
        send_message('{8'($urandom())});
        wait_drained();
    endtask

    // Random messages with idling on both sides.
    task automatic test_random_stream(input int target);
        int len;
        int done;
        done          = 0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        while (done < target) begin
            send_random_message(len);
            done += len;
        end
    endtask

    // Closing stretch at full rate with no idling at all.
    task automatic test_full_rate(input int target);
        int len;
        int done;
        done          = 0;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        while (done < target) begin
            send_random_message(len);
            done += len;
        end
    endtask

    // Receiver: random stall bursts, plus one long hold when a test asks for it.
    always @(posedge aclk) begin : drive_ready
        static int stall_left = 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (hold_request) begin
                stall_left   = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted digest word with the oldest expectation.
    always @(posedge aclk) begin : check_words
        digest_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected word: value=%h number=%0d last=%b",
                         $time, m_block_value, m_block_number, m_last_block);
                errors++;
            end else begin
                want = digest_q.pop_front();
                words_checked++;
                if (m_block_value !== want.value) begin
                    $display("%0t: block_value mismatch: expected %h, actual %h",
                             $time, want.value, m_block_value);
                    errors++;
                end
                if (m_block_number !== want.number) begin
                    $display("%0t: block_number mismatch: expected %0d, actual %0d",
                             $time, want.number, m_block_number);
                    errors++;
                end
                if (m_last_block !== want.last) begin
                    $display("%0t: last_block mismatch: expected %b, actual %b",
                             $time, want.last, m_last_block);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, digest_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_byte();
        test_short_messages();
        test_overflow();
        test_backpressure();
        test_random_stream(165);
        test_full_rate(25);

        // Let the last digest leave, then watch for stray words.
        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d bytes in %0d messages (longest %0d bytes), checked %0d digest words.",
                 bytes_sent, messages_sent, longest_msg, words_checked);
        $display("Covered single-byte and wrapping messages, random stalls and a long hold-off.");
        if (errors == 0 && digest_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
